FILE: sv/ttl_pkg.sv
// ============================================================================
// TTL name cache table package
// Shared types, codes and constants for the expiring name cache table.
// ============================================================================
package ttl_pkg;

    localparam int ENTRIES_DEF = 8;     // default number of table cells
    localparam int NAME_CHARS  = 8;     // longest accepted name in characters
    localparam int NAME_BITS   = 8 * NAME_CHARS;
    localparam int MS_PER_SEC  = 1000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_FIND  = 2'd1,
        OP_ADD   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_INVALID   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIVIDE
    } state_t;

    typedef struct packed {
        op_t         opcode;
        logic [63:0] name_key;
        logic [31:0] ttl_seconds;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] remaining_seconds;
    } res_t;

    // Lookup token that travels down the row of cells, one cell per cycle.
    typedef struct packed {
        logic        active;   // token present at this position
        logic        is_add;   // add or refresh, else find
        logic        insert;   // second walk of an add: purge and insert
        logic        hit;      // a valid entry matched the key
        logic        expired;  // the matching entry had expired (find)
        logic        placed;   // the key was written into a free cell
        logic [63:0] key;
        logic [63:0] expiry;   // new expiry for add
        logic [63:0] diff;     // expiry minus now of a live hit (find)
    } tok_t;

endpackage

FILE: sv/ttl_cell.sv
// ============================================================================
// TTL table cell
// One table entry plus one stage of the lookup token pipeline.
// ============================================================================
module ttl_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic [63:0]   now_ms,
    input  ttl_pkg::tok_t tok_in,
    output ttl_pkg::tok_t tok_out
);

    logic          valid_reg, valid_next;
    logic [63:0]   key_reg, key_next;
    logic [63:0]   exp_reg, exp_next;
    ttl_pkg::tok_t tok_reg, tok_next;
    logic          match;
    logic          expired;

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        key_next   = key_reg;
        exp_next   = exp_reg;
        match      = valid_reg && (key_reg == tok_in.key);
        expired    = (now_ms >= exp_reg);
        if (tok_in.active)
        begin
            if (!tok_in.insert)
            begin
                if (match)
                begin
                    tok_next.hit = 1'b1;
                    if (tok_in.is_add)
                    begin
                        exp_next = tok_in.expiry;
                    end
                    else if (expired)
                    begin
                        valid_next       = 1'b0;
                        tok_next.expired = 1'b1;
                    end
                    else
                    begin
                        tok_next.diff = exp_reg - now_ms;
                    end
                end
            end
            else
            begin
                // Purge an expired entry; the first free cell takes the key.
                if (!valid_reg || expired)
                begin
                    valid_next = 1'b0;
                    if (!tok_in.placed)
                    begin
                        valid_next      = 1'b1;
                        key_next        = tok_in.key;
                        exp_next        = tok_in.expiry;
                        tok_next.placed = 1'b1;
                    end
                end
            end
        end
        if (clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        exp_reg <= exp_next;
    end

    assign tok_out = tok_reg;

endmodule

FILE: sv/ttl_sec_div.sv
// ============================================================================
// TTL seconds divider
// Turns a millisecond span into whole seconds, rounded up and saturated.
// ============================================================================
module ttl_sec_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [63:0] dividend,
    output logic        done,
    output logic [31:0] seconds
);

    // Spans above this many milliseconds round up past the largest count.
    localparam logic [63:0] SatMs  = 64'hFFFF_FFFF * 64'(ttl_pkg::MS_PER_SEC);
    localparam logic [41:0] RoundC = 42'(ttl_pkg::MS_PER_SEC - 1);
    // The rounded span is divided by 8 with a shift and then by 125 with a
    // reciprocal: ceil(2^46 / 125), exact for every span below 2^39.
    localparam logic [39:0] Recip  = 40'd562949953422;
    localparam int          Shift  = 46;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic              sat_reg, sat_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [38:0]       span_reg, span_next;
    logic [79:0]       acc_reg, acc_next;
    logic [41:0]       rounded;
    logic [19:0]       op_a;
    logic [19:0]       op_b;
    logic [39:0]       prod;

    // One 20 by 20 partial product is accumulated per cycle, four in all.
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        span_next = span_reg;
        acc_next  = acc_reg;
        rounded   = dividend[41:0] + RoundC;
        op_a      = cnt_reg[0] ? {1'b0, span_reg[38:20]} : span_reg[19:0];
        op_b      = cnt_reg[1] ? Recip[39:20] : Recip[19:0];
        prod      = 40'(op_a) * 40'(op_b);
        if (load)
        begin
            run_next  = 1'b1;
            sat_next  = (dividend > SatMs);
            cnt_next  = 2'd0;
            span_next = rounded[41:3];
            acc_next  = '0;
        end
        else if (run_reg)
        begin
            case (cnt_reg)
                2'd0:
                begin
                    acc_next = acc_reg + 80'(prod);
                end
                2'd1, 2'd2:
                begin
                    acc_next = acc_reg + {20'd0, prod, 20'd0};
                end
                default:
                begin
                    acc_next = acc_reg + {prod, 40'd0};
                end
            endcase
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg  <= sat_next;
        cnt_reg  <= cnt_next;
        span_reg <= span_next;
        acc_reg  <= acc_next;
    end

    assign seconds = sat_reg ? '1 : acc_reg[Shift +: 32];
    assign done    = done_reg;

endmodule

FILE: sv/ttl_name_cache_table_core.sv
// ============================================================================
// TTL name cache table core
// Fixed table of name keys with millisecond expiry, walked cell by cell.
// ============================================================================
//
// A transaction is accepted on a rising edge with start high and busy low.
// Tick and clear give no result and leave busy low. A find walks the row of
// ENTRIES cells, one cell per cycle; a find that hits a live entry then goes
// through the seconds divider (a reciprocal multiplication built from four
// partial products, one per cycle) before its answer is registered. An add
// that refreshes an existing key takes one walk; an add that inserts or
// reports a full table takes two walks, the second purging expired entries.
// An add with an invalid name answers on the next cycle. Each result is
// shown on result for exactly one cycle with done high; the receiver cannot
// stall it, so it must take every result as it comes. Busy stays high until
// the transaction's result has been issued.
//
module ttl_name_cache_table_core #(
    parameter int ENTRIES = ttl_pkg::ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ttl_pkg::req_t cmd,
    output logic          done,
    output ttl_pkg::res_t result
);

    ttl_pkg::state_t state_reg, state_next;
    logic [63:0]     now_reg, now_next;
    logic            done_reg, done_next;
    ttl_pkg::res_t   result_reg, result_next;

    ttl_pkg::tok_t   tok [ENTRIES+1];
    ttl_pkg::tok_t   head;
    ttl_pkg::tok_t   tail;
    logic            clear;
    logic            accept;
    logic            key_ok;
    logic [41:0]     ttl_ms;
    logic            div_load;
    logic            div_done;
    logic [31:0]     div_secs;

    assign accept = start && (state_reg == ttl_pkg::S_IDLE);
    assign busy   = (state_reg != ttl_pkg::S_IDLE);
    assign tail   = tok[ENTRIES];
    assign tok[0] = head;

    // A name is valid when nonzero and no byte beyond the name length is set.
    assign key_ok = (cmd.name_key != 64'd0) &&
                    ((cmd.name_key >> ttl_pkg::NAME_BITS) == 64'd0);
    assign ttl_ms = 42'(cmd.ttl_seconds) * 42'(ttl_pkg::MS_PER_SEC);

    // The row of cells: the token moves one cell per cycle.
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        ttl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (clear),
            .now_ms  (now_reg),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    ttl_sec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (tail.diff),
        .done     (div_done),
        .seconds  (div_secs)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd.opcode == ttl_pkg::OP_FIND) ||
                        ((cmd.opcode == ttl_pkg::OP_ADD) && key_ok))
                    begin
                        state_next = ttl_pkg::S_WALK;
                    end
                end
            end
            ttl_pkg::S_WALK:
            begin
                if (tail.active)
                begin
                    if (!tail.insert && !tail.is_add && tail.hit && !tail.expired)
                    begin
                        state_next = ttl_pkg::S_DIVIDE;
                    end
                    else if (!tail.insert && tail.is_add && !tail.hit)
                    begin
                        state_next = ttl_pkg::S_WALK;
                    end
                    else
                    begin
                        state_next = ttl_pkg::S_IDLE;
                    end
                end
            end
            ttl_pkg::S_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ttl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ttl_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        head        = '0;
        clear       = 1'b0;
        now_next    = now_reg;
        div_load    = 1'b0;
        done_next   = 1'b0;
        result_next = '{status: ttl_pkg::ST_OK, remaining_seconds: 32'd0};
        case (state_reg)
            ttl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        ttl_pkg::OP_TICK:
                        begin
                            now_next = now_reg + 64'd1;
                        end
                        ttl_pkg::OP_CLEAR:
                        begin
                            clear = 1'b1;
                        end
                        ttl_pkg::OP_FIND:
                        begin
                            head.active = 1'b1;
                            head.key    = cmd.name_key;
                        end
                        ttl_pkg::OP_ADD:
                        begin
                            if (key_ok)
                            begin
                                head.active = 1'b1;
                                head.is_add = 1'b1;
                                head.key    = cmd.name_key;
                                head.expiry = now_reg + 64'(ttl_ms);
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                result_next.status = ttl_pkg::ST_INVALID;
                            end
                        end
                        default:
                        begin
                            head = '0;
                        end
                    endcase
                end
            end
            ttl_pkg::S_WALK:
            begin
                if (tail.active)
                begin
                    if (!tail.insert)
                    begin
                        if (!tail.is_add)
                        begin
                            if (tail.hit && !tail.expired)
                            begin
                                div_load = 1'b1;
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                result_next.status = ttl_pkg::ST_NOT_FOUND;
                            end
                        end
                        else if (tail.hit)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            // No match: walk again, purging and inserting.
                            head.active = 1'b1;
                            head.is_add = 1'b1;
                            head.insert = 1'b1;
                            head.key    = tail.key;
                            head.expiry = tail.expiry;
                        end
                    end
                    else
                    begin
                        done_next          = 1'b1;
                        result_next.status = tail.placed ? ttl_pkg::ST_OK
                                                         : ttl_pkg::ST_FULL;
                    end
                end
            end
            ttl_pkg::S_DIVIDE:
            begin
                if (div_done)
                begin
                    done_next                     = 1'b1;
                    result_next.remaining_seconds = div_secs;
                end
            end
            default:
            begin
                head = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttl_pkg::S_IDLE;
            now_reg   <= 64'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sv/ttl_chk.sv
// ============================================================================
// TTL name cache table checker
// Port-level assertions on the table core, attached by bind.
// ============================================================================
module ttl_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input ttl_pkg::req_t cmd,
    input logic          done,
    input ttl_pkg::res_t result
);

    // A find always walks the table, so the core is busy afterwards.
    a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == ttl_pkg::OP_FIND)) |=> busy)
        else $error("find transaction did not start a table walk");

    // Tick and clear finish at once and never produce a result.
    a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((cmd.opcode == ttl_pkg::OP_TICK) ||
                            (cmd.opcode == ttl_pkg::OP_CLEAR)))
        |=> (!busy && !done))
        else $error("tick or clear produced a result or held busy");

    // Only a found entry reports a nonzero remaining time.
    a_secs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ttl_pkg::ST_OK)) |->
        (result.remaining_seconds == 32'd0))
        else $error("remaining time reported with a failing status");

    // A result follows either an accepted transaction or work in progress.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result strobe with no transaction in flight");

endmodule

bind ttl_name_cache_table_core ttl_chk u_ttl_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

FILE: test/tb.sv
// ============================================================================
// TTL name cache table testbench
// Drives the core with commands and checks each answer against a prediction.
// ============================================================================
//
// The scoreboard keeps its own copy of the millisecond clock and of the name
// table. Every accepted transaction updates that copy, and find or add also
// queue the answer that the core must give. Answers are compared in order as
// they come out of the core.

class ttl_table_scoreboard;

    localparam int SLOTS = ttl_pkg::ENTRIES_DEF;

    bit [63:0]     clock_ms;
    bit            slot_live   [SLOTS];
    bit [63:0]     slot_key    [SLOTS];
    bit [63:0]     slot_expiry [SLOTS];
    ttl_pkg::res_t answers_due [$];
    int            mismatches;

    function new();
        clock_ms   = '0;
        mismatches = 0;
        foreach (slot_live[i]) slot_live[i] = 1'b0;
    endfunction

    // Applies one accepted command to the table copy and queues its answer.
    function void note_command(ttl_pkg::req_t c);
        ttl_pkg::res_t answer;
        int            hit;
        int            free_slot;
        int            used;
        int            name_len;
        bit [63:0]     diff;
        bit [63:0]     secs;
        hit       = -1;
        free_slot = -1;
        used      = 0;
        name_len  = 0;
        answer.status            = ttl_pkg::ST_OK;
        answer.remaining_seconds = '0;
        if (c.opcode == ttl_pkg::OP_TICK)
        begin
            clock_ms = clock_ms + 64'd1;
        end
        else if (c.opcode == ttl_pkg::OP_CLEAR)
        begin
            foreach (slot_live[i]) slot_live[i] = 1'b0;
        end
        else
        begin
            foreach (slot_live[i])
                if (hit < 0 && slot_live[i] && slot_key[i] == c.name_key)
                    hit = i;
            if (c.opcode == ttl_pkg::OP_FIND)
            begin
                if (hit < 0)
                begin
                    answer.status = ttl_pkg::ST_NOT_FOUND;
                end
                else if (clock_ms >= slot_expiry[hit])
                begin
                    slot_live[hit] = 1'b0;
                    answer.status  = ttl_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    diff = slot_expiry[hit] - clock_ms;
                    secs = diff / ttl_pkg::MS_PER_SEC;
                    if (diff % ttl_pkg::MS_PER_SEC != 0)
                        secs = secs + 64'd1;
                    if (secs > 64'hFFFF_FFFF)
                        secs = 64'hFFFF_FFFF;
                    answer.remaining_seconds = secs[31:0];
                end
            end
            else
            begin
                for (int b = 0; b < 8; b++)
                    if (c.name_key[8*b +: 8] != 8'd0)
                        name_len = b + 1;
                if (c.name_key == 64'd0 || name_len > ttl_pkg::NAME_CHARS)
                begin
                    answer.status = ttl_pkg::ST_INVALID;
                end
                else
                begin
                    if (hit < 0)
                    begin
                        // No match: purge expired entries, then take the
                        // lowest free slot.
                        for (int k = 0; k < SLOTS; k++)
                        begin
                            if (slot_live[k] && clock_ms >= slot_expiry[k])
                                slot_live[k] = 1'b0;
                            if (slot_live[k])
                                used++;
                            else if (free_slot < 0)
                                free_slot = k;
                        end
                        if (used >= SLOTS || free_slot < 0)
                        begin
                            answer.status = ttl_pkg::ST_FULL;
                        end
                        else
                        begin
                            hit                 = free_slot;
                            slot_live[hit]      = 1'b1;
                            slot_key[hit]       = c.name_key;
                        end
                    end
                    if (answer.status == ttl_pkg::ST_OK)
                        slot_expiry[hit] = clock_ms
                                         + 64'(c.ttl_seconds) * 64'(ttl_pkg::MS_PER_SEC);
                end
            end
            answers_due.push_back(answer);
        end
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH: %s", what);
        mismatches++;
    endtask

    // Compares one answer from the core with the oldest queued answer.
    task check_answer(ttl_pkg::res_t got);
        ttl_pkg::res_t want;
        if (answers_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected answer status=%0d remaining=%0d",
                                      got.status, got.remaining_seconds));
            return;
        end
        want = answers_due.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      got.status, want.status));
        if (got.remaining_seconds !== want.remaining_seconds)
            report_mismatch($sformatf("remaining_seconds got %0d want %0d",
                                      got.remaining_seconds, want.remaining_seconds));
    endtask

endclass

module tb;

    localparam int SLOTS          = ttl_pkg::ENTRIES_DEF;
    localparam int POOL_SIZE      = 12;
    // A stretch this long without any transaction moving means the core hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Longest job is an add that inserts: two walks of the row of cells.
    localparam int DRAIN_CYCLES   = 3 * SLOTS + 16;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic          done;
    ttl_pkg::req_t cmd;
    ttl_pkg::res_t result;

    ttl_table_scoreboard board = new();
    int                  quiet_cycles = 0;
    logic [63:0]         name_pool [POOL_SIZE];

    ttl_name_cache_table_core #(
        .ENTRIES (SLOTS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Answers are sampled at the rising edge, before the core's registers
    // move. The same block runs the watchdog: any cycle in which a command
    // is taken or an answer comes out counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_answer(result);
            if ((start && !busy) || done)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    // Presents one command at a falling edge, after a random number of idle
    // cycles, and holds it until the core takes it. The scoreboard learns
    // of the transaction at the edge that accepts it. Start stays high
    // after acceptance until the next falling edge, where the next call
    // either raises it with a new command or drops it for an idle cycle.
    task drive_command(input ttl_pkg::op_t op, input logic [63:0] key,
                       input logic [31:0] ttl, input int idle_pct);
        ttl_pkg::req_t c;
        c.opcode      = op;
        c.name_key    = key;
        c.ttl_seconds = ttl;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        board.note_command(c);
    endtask

    // Random traffic. Most names come from a small pool so that refreshes,
    // a full table and expiry purges happen often; the rest are raw 64-bit
    // values and the empty name. Ticks dominate so that the clock actually
    // moves past short lifetimes. Lifetimes of zero expire at once, and
    // one second entries show the rounding of the remaining time.
    task run_random_phase(input int count, input int idle_pct);
        ttl_pkg::op_t op;
        logic [63:0]  key;
        logic [31:0]  ttl;
        int           r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                op = ttl_pkg::OP_TICK;
            else if (r < 77)
                op = ttl_pkg::OP_FIND;
            else if (r < 99)
                op = ttl_pkg::OP_ADD;
            else
                op = ttl_pkg::OP_CLEAR;
            r = $urandom_range(99);
            if (r < 80)
                key = name_pool[$urandom_range(POOL_SIZE - 1)];
            else if (r < 95)
                key = {$urandom, $urandom};
            else
                key = '0;
            r = $urandom_range(99);
            if (r < 40)
                ttl = 32'd0;
            else if (r < 75)
                ttl = 32'd1;
            else if (r < 93)
                ttl = $urandom_range(5, 2);
            else
                ttl = $urandom;
            drive_command(op, key, ttl, idle_pct);
        end
    endtask

    initial
    begin
        int len;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Lookups on an empty table and on the empty name,
        // the empty name rejected by add, the longest lifetime, an entry
        // that is born expired and is dropped by find, a refresh that
        // revives an expired entry, rounding up after one tick, a full
        // table, a refresh while full, and clear.
        drive_command(ttl_pkg::OP_FIND,  64'h41, 32'd0, 0);
        drive_command(ttl_pkg::OP_ADD,   64'd0, 32'd5, 0);
        drive_command(ttl_pkg::OP_FIND,  64'd0, 32'd0, 0);
        drive_command(ttl_pkg::OP_ADD,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
        drive_command(ttl_pkg::OP_FIND,  64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 0);
        drive_command(ttl_pkg::OP_ADD,   64'h41, 32'd0, 0);
        drive_command(ttl_pkg::OP_FIND,  64'h41, 32'd0, 0);
        drive_command(ttl_pkg::OP_ADD,   64'h41, 32'd0, 0);
        drive_command(ttl_pkg::OP_ADD,   64'h41, 32'd2, 0);
        drive_command(ttl_pkg::OP_TICK,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
        drive_command(ttl_pkg::OP_FIND,  64'h41, 32'd0, 0);
        drive_command(ttl_pkg::OP_ADD,   64'h8877_6655_4433_2211, 32'd1, 0);
        for (int i = 0; i < 5; i++)
            drive_command(ttl_pkg::OP_ADD, 64'h3130 + i, 32'd3, 0);
        drive_command(ttl_pkg::OP_ADD,   64'h5A5A, 32'd3, 0);
        drive_command(ttl_pkg::OP_ADD,   64'h8877_6655_4433_2211, 32'hAAAA_5555, 0);
        drive_command(ttl_pkg::OP_FIND,  64'h8877_6655_4433_2211, 32'h5555_AAAA, 0);
        drive_command(ttl_pkg::OP_CLEAR, 64'd0, 32'd0, 0);
        drive_command(ttl_pkg::OP_FIND,  64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 0);
        drive_command(ttl_pkg::OP_ADD,   64'h5A5A, 32'd1, 0);

        // Pool names have one to eight characters with a nonzero top byte.
        foreach (name_pool[i])
        begin
            len          = $urandom_range(8, 1);
            name_pool[i] = '0;
            for (int b = 0; b < len - 1; b++)
                name_pool[i][8*b +: 8] = 8'($urandom);
            name_pool[i][8*(len-1) +: 8] = 8'($urandom_range(255, 1));
        end

        // Back to back, a mostly idle sender, a lightly idle sender, and
        // back to back again.
        run_random_phase(450, 0);
        run_random_phase(450, 83);
        run_random_phase(450, 28);
        run_random_phase(450, 0);

        @(negedge clk);
        start <= 1'b0;

        // Wait for every queued answer, then give the core time to show any
        // answer that it should not produce.
        while (board.answers_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: ttl_name_cache_table_core.f
sv/ttl_pkg.sv
sv/ttl_cell.sv
sv/ttl_sec_div.sv
sv/ttl_name_cache_table_core.sv
sv/ttl_chk.sv
test/tb.sv
